// ===== sv/cpte_pkg.sv =====
// ----------------------------------------------------------------------------
// cpte_pkg
// Shared types, constants and the CP437 reverse lookup for the code point
// text encoder.
// ----------------------------------------------------------------------------
package cpte_pkg;

  // Field widths fixed by the interface.
  localparam int CP_W       = 21;
  localparam int BYTE_W     = 8;
  localparam int CNT_OUT_W  = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int MAX_BYTES  = 7;
  localparam int LEN_W      = 3;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_ENCODING_MODE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLACEMENT_BYTE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ALLOW_LOSSY      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CRLF_MODE        = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INCLUDE_BOM      = 3'd4;

  // Code point limits.
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_REPLACE  = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_ASCII_MAX  = 21'h00007F;
  localparam logic [CP_W-1:0] CP_LATIN1_MAX = 21'h0000FF;
  localparam logic [CP_W-1:0] CP_UTF8_2B  = 21'h000800;
  localparam logic [CP_W-1:0] CP_UTF8_3B  = 21'h010000;

  // Byte values.
  localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
  localparam logic [2:0][BYTE_W-1:0] BOM_SEQ = {8'hBF, 8'hBB, 8'hEF};
  localparam logic [BYTE_W-1:0] REPL_RESET = 8'd63;

  typedef enum logic [1:0] {
    MODE_UTF8   = 2'd0,
    MODE_ASCII  = 2'd1,
    MODE_LATIN1 = 2'd2,
    MODE_CP437  = 2'd3
  } enc_mode_t;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_LOSSY  = 2'd1,
    ST_FAIL   = 2'd2
  } status_t;

  // Current register settings.
  typedef struct packed {
    enc_mode_t         mode;
    logic [BYTE_W-1:0] repl;
    logic              lossy;
    logic              crlf;
    logic              bom;
  } cfg_t;

  // All results of one item, handed from the encoder to the serializer.
  typedef struct packed {
    logic [LEN_W-1:0]                  len;
    logic [MAX_BYTES-1:0][BYTE_W-1:0]  bytes;
    logic [MAX_BYTES-1:0][1:0]         stat;
    logic [CP_W-1:0]                   fcp;
    logic [CNT_OUT_W-1:0]              cnt;
  } burst_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] idx;
  } cp437_hit_t;

  // Upper half of code page 437, indexed by byte value minus 0x80.
  localparam logic [15:0] CP437_HIGH [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

  // Parallel compare against every table entry; the lowest index wins.
  function automatic cp437_hit_t cp437_lookup(input logic [CP_W-1:0] cp);
    cp437_hit_t res;
    res = '0;
    for (int i = 127; i >= 0; i--) begin
      if (cp == {5'd0, CP437_HIGH[i]}) begin
        res.hit = 1'b1;
        res.idx = 7'(i);
      end
    end
    return res;
  endfunction

endpackage

// ===== sv/cpte_cfg.sv =====
// ----------------------------------------------------------------------------
// cpte_cfg
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module cpte_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cpte_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [cpte_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output cpte_pkg::cfg_t                   cfg
);

  cpte_pkg::cfg_t cfg_r;

  // Register file; writes to an unknown index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= cpte_pkg::MODE_UTF8;
      cfg_r.repl  <= cpte_pkg::REPL_RESET;
      cfg_r.lossy <= 1'b0;
      cfg_r.crlf  <= 1'b0;
      cfg_r.bom   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cpte_pkg::REG_ENCODING_MODE:    cfg_r.mode  <= cpte_pkg::enc_mode_t'(cfg_wdata[1:0]);
        cpte_pkg::REG_REPLACEMENT_BYTE: cfg_r.repl  <= cfg_wdata;
        cpte_pkg::REG_ALLOW_LOSSY:      cfg_r.lossy <= cfg_wdata[0];
        cpte_pkg::REG_CRLF_MODE:        cfg_r.crlf  <= cfg_wdata[0];
        cpte_pkg::REG_INCLUDE_BOM:      cfg_r.bom   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/cpte_encode.sv =====
// ----------------------------------------------------------------------------
// cpte_encode
// Input register, sanitizing and encoding logic, and the running lossy
// counter and sticky failure state. Produces all bytes of one item at once.
// ----------------------------------------------------------------------------
module cpte_encode #(
  parameter int LOSSY_COUNT_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cpte_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cpte_pkg::CP_W-1:0]   in_cp,
  input  logic                        in_first,
  input  logic                        buf_free,
  output logic                        load,
  output cpte_pkg::burst_t            burst
);

  localparam int CntW = (LOSSY_COUNT_BITS < cpte_pkg::CNT_OUT_W) ?
                        LOSSY_COUNT_BITS : cpte_pkg::CNT_OUT_W;

  logic                        item_vld_r;
  logic [cpte_pkg::CP_W-1:0]   cp_in_r;
  logic                        first_r;
  logic [LOSSY_COUNT_BITS-1:0] total_r;
  logic [LOSSY_COUNT_BITS-1:0] total_nxt;
  logic                        failed_r;

  logic [cpte_pkg::CP_W-1:0]   cp;
  cpte_pkg::cp437_hit_t        hit;
  logic                        fail;
  logic                        lossy_ev;
  logic                        found;
  logic                        single;
  logic [7:0]                  sb;
  logic [3:0][7:0]             m;
  logic [2:0]                  mlen;
  cpte_pkg::status_t           mstat;
  logic                        bom_on;
  logic [LOSSY_COUNT_BITS-1:0] cnt_base;
  logic [cpte_pkg::CNT_OUT_W-1:0] cnt_ext;

  assign load     = item_vld_r && buf_free;
  assign in_ready = !item_vld_r || load;

  // Input holding register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cp_in_r <= in_cp;
      first_r <= in_first;
    end
  end

  // Surrogates and out-of-range values become the replacement character.
  always_comb begin
    if (cp_in_r > cpte_pkg::CP_MAX ||
        (cp_in_r >= cpte_pkg::CP_SURR_LO && cp_in_r <= cpte_pkg::CP_SURR_HI)) begin
      cp = cpte_pkg::CP_REPLACE;
    end else begin
      cp = cp_in_r;
    end
  end

  assign hit = cpte_pkg::cp437_lookup(cp);

  // Encode the code point into up to four bytes.
  always_comb begin
    fail     = 1'b0;
    lossy_ev = 1'b0;
    found    = 1'b0;
    single   = 1'b1;
    sb       = cp[7:0];
    m        = '0;
    mlen     = 3'd1;
    mstat    = cpte_pkg::ST_NORMAL;
    if (failed_r && !first_r) begin
      fail = 1'b1;
    end else begin
      unique case (cfg.mode)
        cpte_pkg::MODE_UTF8: begin
          found = 1'b1;
          if (cp < cpte_pkg::CP_UTF8_2B && cp > cpte_pkg::CP_ASCII_MAX) begin
            single = 1'b0;
            m[0]   = {3'b110, cp[10:6]};
            m[1]   = {2'b10, cp[5:0]};
            mlen   = 3'd2;
          end else if (cp >= cpte_pkg::CP_UTF8_2B && cp < cpte_pkg::CP_UTF8_3B) begin
            single = 1'b0;
            m[0]   = {4'b1110, cp[15:12]};
            m[1]   = {2'b10, cp[11:6]};
            m[2]   = {2'b10, cp[5:0]};
            mlen   = 3'd3;
          end else if (cp >= cpte_pkg::CP_UTF8_3B) begin
            single = 1'b0;
            m[0]   = {5'b11110, cp[20:18]};
            m[1]   = {2'b10, cp[17:12]};
            m[2]   = {2'b10, cp[11:6]};
            m[3]   = {2'b10, cp[5:0]};
            mlen   = 3'd4;
          end
        end
        cpte_pkg::MODE_ASCII:  found = (cp <= cpte_pkg::CP_ASCII_MAX);
        cpte_pkg::MODE_LATIN1: found = (cp <= cpte_pkg::CP_LATIN1_MAX);
        cpte_pkg::MODE_CP437: begin
          if (cp <= cpte_pkg::CP_ASCII_MAX) begin
            found = 1'b1;
          end else if (hit.hit) begin
            found = 1'b1;
            sb    = {1'b1, hit.idx};
          end
        end
        default: found = 1'b0;
      endcase
      // Unrepresentable: replace or fail.
      if (!found) begin
        if (cfg.lossy) begin
          lossy_ev = 1'b1;
          sb       = cfg.repl;
          mstat    = cpte_pkg::ST_LOSSY;
        end else begin
          fail = 1'b1;
        end
      end
    end

    if (fail) begin
      single = 1'b0;
      m      = '0;
      mlen   = 3'd1;
      mstat  = cpte_pkg::ST_FAIL;
    end else if (single) begin
      // A line feed gains a carriage return in front when enabled.
      if (cfg.crlf && sb == cpte_pkg::BYTE_LF) begin
        m[0] = cpte_pkg::BYTE_CR;
        m[1] = cpte_pkg::BYTE_LF;
        mlen = 3'd2;
      end else begin
        m[0] = sb;
        mlen = 3'd1;
      end
    end
  end

  // Saturating lossy counter, cleared by the first item of a text.
  always_comb begin
    cnt_base  = first_r ? '0 : total_r;
    total_nxt = cnt_base;
    if (lossy_ev && cnt_base != {LOSSY_COUNT_BITS{1'b1}}) begin
      total_nxt = cnt_base + LOSSY_COUNT_BITS'(1);
    end
    cnt_ext = '0;
    cnt_ext[CntW-1:0] = total_nxt[CntW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      failed_r <= 1'b0;
    end else if (load) begin
      total_r  <= total_nxt;
      failed_r <= fail;
    end
  end

  // Assemble the byte list, with the byte-order mark in front if due.
  always_comb begin
    bom_on = first_r && cfg.mode == cpte_pkg::MODE_UTF8 && cfg.bom;
    if (bom_on) begin
      burst.bytes = {m, cpte_pkg::BOM_SEQ};
      burst.stat  = {{4{mstat}}, 6'd0};
      burst.len   = mlen + 3'd3;
    end else begin
      burst.bytes = {24'd0, m};
      burst.stat  = {6'd0, {4{mstat}}};
      burst.len   = mlen;
    end
    burst.fcp = fail ? cp : '0;
    burst.cnt = cnt_ext;
  end

endmodule

// ===== sv/cpte_serial.sv =====
// ----------------------------------------------------------------------------
// cpte_serial
// Result register holding the bytes of one item; sends them one request
// per cycle on the result channel while the receiver is ready.
// ----------------------------------------------------------------------------
module cpte_serial (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  cpte_pkg::burst_t     burst,
  output logic                 buf_free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,
  output logic [1:0]           out_tuser,
  output logic                 out_tlast
);

  logic                            vld_r;
  logic [cpte_pkg::LEN_W-1:0]      idx_r;
  cpte_pkg::burst_t                burst_r;
  logic                            is_last;
  logic                            done;
  logic [1:0]                      stat;

  assign is_last  = (idx_r == burst_r.len - 3'd1);
  assign done     = vld_r && out_tready && is_last;
  assign buf_free = !vld_r || done;

  // Buffer control and byte index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (done) begin
      vld_r <= 1'b0;
    end else if (vld_r && out_tready) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_r <= burst;
    end
  end

  // Result fields for the current byte.
  always_comb begin
    stat       = burst_r.stat[idx_r];
    out_tvalid = vld_r;
    out_tlast  = is_last;
    out_tuser  = stat;
    out_tdata  = {3'd0,
                  (stat == cpte_pkg::ST_FAIL) ? burst_r.fcp : 21'd0,
                  burst_r.cnt,
                  burst_r.bytes[idx_r]};
  end

endmodule

// ===== sv/code_point_text_encoder_top.sv =====
// ----------------------------------------------------------------------------
// code_point_text_encoder_top
// Encodes Unicode code points as UTF-8, ASCII, Latin-1 or CP437 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one code point per request; in_tuser marks the
//   first item of a text, which clears the lossy count and a sticky failure
//   and lets a UTF-8 byte-order mark go out first. The result channel gives
//   one request per output byte (or one failure request), with out_tlast on
//   the final request of each input item.
//   An accepted item passes the input register and then the result register
//   before its first result shows. Throughput: each item has one to seven
//   results, which the result register sends at one byte per cycle while
//   out_tready is high, so single-result items then flow at one per cycle.
//   Reset clears the configuration to its defaults, the counter and the
//   failure state, and empties both holding registers.
//   When the receiver stalls, the current result holds, one further item
//   waits in the input register, and in_tready drops after that.
//   The user must write configuration only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module code_point_text_encoder_top #(
  parameter int LOSSY_COUNT_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [cpte_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [cpte_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Input channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,   // code_point[20:0], zero pad
  input  logic                             in_tuser,   // first_item
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [63:0]                      out_tdata,  // out_byte[7:0],
                                                       // lossy_count[39:8],
                                                       // failed_code_point[60:40]
  output logic [1:0]                       out_tuser,  // status[1:0]
  output logic                             out_tlast   // last
);

  cpte_pkg::cfg_t   cfg;
  cpte_pkg::burst_t burst;
  logic             load;
  logic             buf_free;

  cpte_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cpte_encode #(
    .LOSSY_COUNT_BITS (LOSSY_COUNT_BITS)
  ) u_encode (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cp    (in_tdata[cpte_pkg::CP_W-1:0]),
    .in_first (in_tuser),
    .buf_free (buf_free),
    .load     (load),
    .burst    (burst)
  );

  cpte_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .burst      (burst),
    .buf_free   (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sv/cpte_checker.sv =====
// ----------------------------------------------------------------------------
// cpte_checker
// Port-level checks for the code point text encoder, bound to the top level.
// ----------------------------------------------------------------------------
module cpte_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result request keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result request changed");

  // A failure carries no byte and ends its item.
  a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == cpte_pkg::ST_FAIL |->
      out_tdata[7:0] == 8'd0 && out_tlast)
    else $error("failure request has a byte or is not last");

  // Only a failure carries a code point.
  a_fcp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != cpte_pkg::ST_FAIL |-> out_tdata[60:40] == 21'd0)
    else $error("failed code point on a non-failure request");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind code_point_text_encoder_top cpte_checker u_cpte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
